@@ hw/rtl/ecpr_pkg.sv @@
// ---------------------------------------------------------------------------
// ecpr_pkg
// Shared constants, sweep pass codes and frame status types for the
// enhanced clock page replacement block.
// ---------------------------------------------------------------------------
package ecpr_pkg;

   // default sizes
   localparam int FRAMES_DEF    = 8;
   localparam int PAGE_BITS_DEF = 16;

   // fixed port widths
   localparam int PAGE_W      = 16;
   localparam int FRAME_IDX_W = 3;
   localparam int CSR_W       = 4;

   // victim search passes, in order
   typedef enum logic [1:0] {
      PASS_CLEAN_EMPTY = 2'd0,  // empty or clean unreferenced
      PASS_DIRTY_CLEAR = 2'd1,  // dirty unreferenced, clear R on the way
      PASS_CLEAN       = 2'd2,  // clean unreferenced
      PASS_DIRTY       = 2'd3   // dirty unreferenced
   } pass_type;

   // status bits of the frame under inspection
   typedef struct packed {
      logic valid;
      logic referenced;
      logic modified;
   } frame_stat_type;

   // what the compare unit is asked to do
   typedef struct packed {
      logic     scan;   // 1: tag lookup, 0: victim class check
      pass_type pass;
   } unit_ctl_type;

   // compare unit verdicts
   typedef struct packed {
      logic tag_hit;
      logic take;
   } unit_res_type;

endpackage

@@ hw/rtl/ecpr_ram.sv @@
// ---------------------------------------------------------------------------
// ecpr_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module ecpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ecpr_frame_unit.sv @@
// ---------------------------------------------------------------------------
// ecpr_frame_unit
// Shared compare unit: checks one frame per cycle, either its tag against
// the requested page or its R/M class against the current sweep pass.
// ---------------------------------------------------------------------------
module ecpr_frame_unit
   import ecpr_pkg::*;
#(
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  unit_ctl_type         ctl,
   input  frame_stat_type       stat,
   input  logic [PAGE_BITS-1:0] tag,
   input  logic [PAGE_BITS-1:0] page,
   output unit_res_type         res
);

   logic want_dirty;
   logic class_match;
   logic empty_take;

   // odd passes look for dirty frames
   assign want_dirty = (ctl.pass == PASS_DIRTY_CLEAR) || (ctl.pass == PASS_DIRTY);

   assign class_match = stat.valid && !stat.referenced && (stat.modified == want_dirty);
   assign empty_take  = (ctl.pass == PASS_CLEAN_EMPTY) && !stat.valid;

   assign res.tag_hit = ctl.scan && stat.valid && (tag == page);
   assign res.take    = !ctl.scan && (empty_take || class_match);

endmodule

@@ hw/rtl/enhanced_clock_page_replacement.sv @@
// ---------------------------------------------------------------------------
// enhanced_clock_page_replacement
// Enhanced second-chance clock page replacement with one shared frame
// compare unit under a small sequencer.
// ---------------------------------------------------------------------------
// Each request (page number, write flag) is handled alone; req_ready is high
// only while the sequencer is idle. The tag lookup reads the page tag RAM one
// frame per cycle, pipelined, and stops early on a hit. A miss then sweeps
// the frames from the clock hand, one frame per cycle through the compare
// unit (three full passes find nothing only when every frame is dirty, and
// the fourth then takes the first frame it looks at). S_EVICT_RD then reads
// the evicted tag, S_FILL loads the new page, and S_FINISH hands the
// response to the output register once it is free. The output register lets
// the next request be accepted while a response still waits.
// The user must write the active frame count through csr_wr_en/csr_wr_data
// only while the block is idle; the block does not enforce this. 0 acts as 1
// and values above FRAMES act as FRAMES.
// ---------------------------------------------------------------------------
module enhanced_clock_page_replacement
   import ecpr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PAGE_W-1:0]      req_page_number,
   input  logic                   req_is_write,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic [FRAME_IDX_W-1:0] rsp_frame_index,
   output logic                   rsp_evicted_valid,
   output logic [PAGE_W-1:0]      rsp_evicted_page,
   output logic                   rsp_evicted_dirty,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CSR_W-1:0]       csr_wr_data
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN     = 6'b000010,
      S_SWEEP    = 6'b000100,
      S_EVICT_RD = 6'b001000,
      S_FILL     = 6'b010000,
      S_FINISH   = 6'b100000
   } state_type;

   state_type             state_ff, state_in;

   // frame state
   logic [FRAMES-1:0]     valid_ff;
   logic [FRAMES-1:0]     ref_ff;
   logic [FRAMES-1:0]     mod_ff;
   logic [IDX_W-1:0]      hand_ff;
   logic [CNT_W-1:0]      nact_ff;

   // request being worked on
   logic [PAGE_BITS-1:0]  page_ff;
   logic                  wr_ff;

   // lookup pipeline
   logic [IDX_W-1:0]      scan_ff;
   logic                  issue_done_ff;
   logic                  cmp_vld_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;

   // sweep
   logic [IDX_W-1:0]      h_ff;
   logic [IDX_W-1:0]      step_ff;
   pass_type              pass_ff;
   logic [IDX_W-1:0]      vic_ff;

   // result waiting for the output register
   logic                  res_hit_ff;
   logic [IDX_W-1:0]      res_frame_ff;
   logic                  res_ev_valid_ff;
   logic [PAGE_BITS-1:0]  res_ev_page_ff;
   logic                  res_ev_dirty_ff;

   // output register
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [FRAME_IDX_W-1:0] rsp_frame_ff;
   logic                  rsp_ev_valid_ff;
   logic [PAGE_W-1:0]     rsp_ev_page_ff;
   logic                  rsp_ev_dirty_ff;

   // tag RAM
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [PAGE_BITS-1:0]  ram_rd_data;

   // compare unit
   unit_ctl_type          unit_ctl;
   frame_stat_type        unit_stat;
   unit_res_type          unit_res;
   logic [IDX_W-1:0]      sel_idx;

   logic                  accept;
   logic                  out_free;
   logic                  scan_last;
   logic                  cmp_last;
   logic                  h_last;
   logic                  step_last;
   logic                  vic_last;
   logic [IDX_W-1:0]      h_next;
   logic [IDX_W-1:0]      sweep_start;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // last-frame checks against the active count
   assign scan_last = (CNT_W'(scan_ff) + CNT_W'(1)) == nact_ff;
   assign cmp_last  = (CNT_W'(cmp_idx_ff) + CNT_W'(1)) == nact_ff;
   assign h_last    = (CNT_W'(h_ff) + CNT_W'(1)) == nact_ff;
   assign step_last = (CNT_W'(step_ff) + CNT_W'(1)) == nact_ff;
   assign vic_last  = (CNT_W'(vic_ff) + CNT_W'(1)) == nact_ff;

   assign h_next      = h_last ? '0 : h_ff + IDX_W'(1);
   assign sweep_start = (CNT_W'(hand_ff) < nact_ff) ? hand_ff : '0;

   // steer the compare unit
   assign sel_idx             = state_ff == S_SCAN ? cmp_idx_ff : h_ff;
   assign unit_ctl.scan       = state_ff == S_SCAN;
   assign unit_ctl.pass       = pass_ff;
   assign unit_stat.valid      = valid_ff[sel_idx];
   assign unit_stat.referenced = ref_ff[sel_idx];
   assign unit_stat.modified   = mod_ff[sel_idx];

   ecpr_frame_unit #(
      .PAGE_BITS (PAGE_BITS)
   ) u_unit (
      .ctl  (unit_ctl),
      .stat (unit_stat),
      .tag  (ram_rd_data),
      .page (page_ff),
      .res  (unit_res)
   );

   // tag RAM: lookup reads in scan, victim read before fill
   assign ram_rd_addr = state_ff == S_SCAN ? scan_ff : vic_ff;
   assign ram_wr_en   = state_ff == S_FILL;

   ecpr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (FRAMES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (vic_ff),
      .wr_data (page_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cmp_vld_ff && unit_res.tag_hit) begin
               state_in = S_FINISH;
            end else if (cmp_vld_ff && cmp_last) begin
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (unit_res.take || (step_last && pass_ff == PASS_DIRTY)) begin
               state_in = S_EVICT_RD;
            end
         end
         S_EVICT_RD: state_in = S_FILL;
         S_FILL:     state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration: clamp the frame count on write
   always_ff @(posedge clock) begin
      if (reset) begin
         nact_ff <= CNT_W'(FRAMES);
      end else if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            nact_ff <= CNT_W'(1);
         end else if (32'(csr_wr_data) > FRAMES) begin
            nact_ff <= CNT_W'(FRAMES);
         end else begin
            nact_ff <= CNT_W'(csr_wr_data);
         end
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= PAGE_BITS'(req_page_number);
         wr_ff   <= req_is_write;
      end
   end

   // lookup pipeline: issue one tag read a cycle, compare the previous one
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= '0;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         cmp_idx_ff    <= '0;
      end else if (accept) begin
         scan_ff       <= '0;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
      end else if (state_ff == S_SCAN) begin
         cmp_vld_ff <= !issue_done_ff;
         cmp_idx_ff <= scan_ff;
         if (scan_last) begin
            issue_done_ff <= 1'b1;
         end else begin
            scan_ff <= scan_ff + IDX_W'(1);
         end
      end
   end

   // sweep position, pass and victim
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN && cmp_vld_ff && cmp_last && !unit_res.tag_hit) begin
         h_ff    <= sweep_start;
         step_ff <= '0;
         pass_ff <= PASS_CLEAN_EMPTY;
      end else if (state_ff == S_SWEEP) begin
         if (unit_res.take) begin
            vic_ff <= h_ff;
         end else begin
            h_ff <= h_next;
            if (step_last) begin
               step_ff <= '0;
               case (pass_ff)
                  PASS_CLEAN_EMPTY: pass_ff <= PASS_DIRTY_CLEAR;
                  PASS_DIRTY_CLEAR: pass_ff <= PASS_CLEAN;
                  PASS_CLEAN:       pass_ff <= PASS_DIRTY;
                  default:          vic_ff  <= h_next;
               endcase
            end else begin
               step_ff <= step_ff + IDX_W'(1);
            end
         end
      end
   end

   // frame status bits and clock hand
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ref_ff   <= '0;
         mod_ff   <= '0;
         hand_ff  <= '0;
      end else begin
         case (state_ff)
            S_SCAN: begin
               if (cmp_vld_ff && unit_res.tag_hit) begin
                  ref_ff[cmp_idx_ff] <= 1'b1;
                  if (wr_ff) mod_ff[cmp_idx_ff] <= 1'b1;
               end
            end
            S_SWEEP: begin
               if (pass_ff == PASS_DIRTY_CLEAR) ref_ff[h_ff] <= 1'b0;
            end
            S_FILL: begin
               valid_ff[vic_ff] <= 1'b1;
               ref_ff[vic_ff]   <= 1'b1;
               mod_ff[vic_ff]   <= wr_ff;
               hand_ff          <= vic_last ? '0 : vic_ff + IDX_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   // build the result
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN && cmp_vld_ff && unit_res.tag_hit) begin
         res_hit_ff      <= 1'b1;
         res_frame_ff    <= cmp_idx_ff;
         res_ev_valid_ff <= 1'b0;
         res_ev_page_ff  <= '0;
         res_ev_dirty_ff <= 1'b0;
      end else if (state_ff == S_FILL) begin
         res_hit_ff      <= 1'b0;
         res_frame_ff    <= vic_ff;
         res_ev_valid_ff <= valid_ff[vic_ff];
         res_ev_page_ff  <= valid_ff[vic_ff] ? ram_rd_data : '0;
         res_ev_dirty_ff <= valid_ff[vic_ff] && mod_ff[vic_ff];
      end
   end

   // output register: load when free, drop on handoff
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && out_free) begin
         rsp_hit_ff      <= res_hit_ff;
         rsp_frame_ff    <= FRAME_IDX_W'(res_frame_ff);
         rsp_ev_valid_ff <= res_ev_valid_ff;
         rsp_ev_page_ff  <= PAGE_W'(res_ev_page_ff);
         rsp_ev_dirty_ff <= res_ev_dirty_ff;
      end
   end

   assign req_ready         = state_ff == S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_evicted_dirty = rsp_ev_dirty_ff;

endmodule
